// ===== design/dgr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dgr_pkg;

    // graph size and field widths
    localparam int NODES   = 32;
    localparam int NODE_W  = $clog2(NODES);
    localparam int FIELD_W = 5;
    localparam int CMD_W   = 2;

    // request commands
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef logic [NODES-1:0]  t_row;
    typedef logic [NODE_W-1:0] t_node;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_WALK,
        S_DONE
    } t_state;

    // controls from the sequencer to the search registers
    typedef struct packed {
        logic load;
        logic step;
        logic clear;
    } t_walk_ctl;

    // node field names an existing node
    function automatic logic node_ok(input logic [FIELD_W-1:0] n);
        return int'(n) < NODES;
    endfunction

    function automatic t_node node_idx(input logic [FIELD_W-1:0] n);
        return NODE_W'(n);
    endfunction

endpackage

`default_nettype wire

// ===== design/dgr_adj.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dgr_adj
    import dgr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_set,
    input  wire t_node i_set_src,
    input  wire t_node i_set_dst,
    input  wire logic  i_clear,
    input  wire t_node i_rd_addr,
    output t_row       o_rd_row
);

    // adjacency bit matrix: row s, bit d is the edge s -> d
    t_row r_adj [NODES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < NODES; i++) begin
                r_adj[i] <= '0;
            end
        end else if (i_set) begin
            r_adj[i_set_src][i_set_dst] <= 1'b1;
        end
    end

    assign o_rd_row = r_adj[i_rd_addr];

endmodule

`default_nettype wire

// ===== design/dgr_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dgr_walk
    import dgr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_walk_ctl i_ctl,
    input  wire t_row      i_row,
    output t_node          o_pick,
    output logic           o_empty,
    output t_row           o_reached
);

    t_row  r_reached;
    t_row  r_pending;
    t_row  n_reached;
    t_row  n_pending;
    t_row  fresh;
    t_node pick;

    // lowest pending node
    always_comb begin
        pick = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (r_pending[i]) begin
                pick = NODE_W'(i);
            end
        end
    end

    assign fresh = i_row & ~r_reached;

    always_comb begin
        n_reached = r_reached;
        n_pending = r_pending;
        priority if (i_ctl.clear) begin
            n_reached = '0;
            n_pending = '0;
        end else if (i_ctl.load) begin
            n_reached = i_row;
            n_pending = i_row;
        end else if (i_ctl.step) begin
            n_reached = r_reached | fresh;
            n_pending = (r_pending & ~(t_row'(1) << pick)) | fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reached <= '0;
            r_pending <= '0;
        end else begin
            r_reached <= n_reached;
            r_pending <= n_pending;
        end
    end

    assign o_pick    = pick;
    assign o_empty   = (r_pending == '0);
    assign o_reached = r_reached;

endmodule

`default_nettype wire

// ===== design/directed_graph_reachability.sv =====
// channel   | signals                                        | direction
// request   | i_req_valid, o_req_ready, i_command,           | in
//           | i_src_node, i_dst_node                         |
// response  | o_rsp_valid, i_rsp_ready, o_path_found         | out
//
// add edge and clear graph give no response
// a query passes through S_LOAD, S_WALK and S_DONE: the load state reads the source row,
// the walk expands one reached row per step until nothing is pending,
// and the done state posts the response
// reset (synchronous, active low) empties the graph at once
// a waiting response leaves requests open but holds a later query in S_DONE
`timescale 1ns / 1ps
`default_nettype none

module directed_graph_reachability
    import dgr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    output logic                    o_req_ready,
    input  wire logic [CMD_W-1:0]   i_command,
    input  wire logic [FIELD_W-1:0] i_src_node,
    input  wire logic [FIELD_W-1:0] i_dst_node,
    output logic                    o_rsp_valid,
    input  wire logic               i_rsp_ready,
    output logic                    o_path_found
);

    t_state    r_state;
    t_state    n_state;
    t_node     r_src;
    t_node     r_dst;
    logic      r_ok;
    logic      r_rsp_valid;
    logic      r_path_found;

    logic      req_acc;
    logic      req_ok;
    logic      adj_set;
    t_node     rd_addr;
    t_row      rd_row;
    t_row      walk_row;
    t_walk_ctl walk_ctl;
    t_node     pick;
    logic      empty;
    t_row      reached;
    logic      rsp_load;

    assign req_acc = i_req_valid && o_req_ready;
    // both ends must name real nodes
    assign req_ok  = node_ok(i_src_node) && node_ok(i_dst_node);

    // adjacency matrix, one row read per cycle
    dgr_adj u_adj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_set     (adj_set),
        .i_set_src (node_idx(i_src_node)),
        .i_set_dst (node_idx(i_dst_node)),
        .i_clear   (walk_ctl.clear),
        .i_rd_addr (rd_addr),
        .o_rd_row  (rd_row)
    );

    // a query naming a missing node starts from an empty set and answers 0
    assign walk_row = r_ok ? rd_row : '0;

    // reached and pending sets with the per-step merge
    dgr_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (walk_ctl),
        .i_row     (walk_row),
        .o_pick    (pick),
        .o_empty   (empty),
        .o_reached (reached)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc && i_command == CMD_QUERY) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (empty) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_req_ready    = (r_state == S_IDLE);
        adj_set        = req_acc && i_command == CMD_ADD && req_ok;
        walk_ctl.clear = req_acc && i_command == CMD_CLEAR;
        walk_ctl.load  = (r_state == S_LOAD);
        walk_ctl.step  = (r_state == S_WALK) && !empty;
        rd_addr        = (r_state == S_LOAD) ? r_src : pick;
        rsp_load       = (r_state == S_DONE) && (!r_rsp_valid || i_rsp_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // query operands held for the walk
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_src <= node_idx(i_src_node);
            r_dst <= node_idx(i_dst_node);
            r_ok  <= req_ok;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (rsp_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_load) begin
            r_path_found <= reached[r_dst];
        end
    end

    assign o_rsp_valid  = r_rsp_valid;
    assign o_path_found = r_path_found;

endmodule

`default_nettype wire

// ===== design/dgr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dgr_checker
    import dgr_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_req_valid,
    input wire logic               o_req_ready,
    input wire logic [CMD_W-1:0]   i_command,
    input wire logic [FIELD_W-1:0] i_src_node,
    input wire logic [FIELD_W-1:0] i_dst_node,
    input wire logic               o_rsp_valid,
    input wire logic               i_rsp_ready,
    input wire logic               o_path_found
);

    logic req_acc;
    assign req_acc = i_req_valid && o_req_ready;

    // idle with no response right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> o_req_ready && !o_rsp_valid)
        else $error("not idle after reset");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_path_found))
        else $error("response dropped or changed while stalled");

    // a query keeps the block busy for the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && i_command == CMD_QUERY |=> !o_req_ready)
        else $error("request taken during a query");

    // commands other than a query produce no response
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && i_command != CMD_QUERY && !o_rsp_valid |=> !o_rsp_valid)
        else $error("response without a query");

endmodule

bind directed_graph_reachability dgr_checker u_dgr_checker (.*);

`default_nettype wire

// ===== dv/tb_directed_graph_reachability.sv =====
`timescale 1ns / 1ps

module tb_directed_graph_reachability
    import dgr_pkg::*;
;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_REQS  = 1900;
    localparam int IDLE_PCT     = 17;
    localparam int DRAIN_CYCLES = NODES + 8;
    localparam int CYCLE_LIMIT  = 500000;
    // steady stretch where neither side idles
    localparam int CALM_FROM    = 700;
    localparam int CALM_TO      = 1000;

    // command code the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]   command;
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] dst;
    } graph_req_t;

    typedef struct {
        logic               found;
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] dst;
    } path_answer_t;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_req_valid = 1'b0;
    logic               o_req_ready;
    logic [CMD_W-1:0]   i_command   = CMD_ADD;
    logic [FIELD_W-1:0] i_src_node  = '0;
    logic [FIELD_W-1:0] i_dst_node  = '0;
    logic               o_rsp_valid;
    logic               i_rsp_ready = 1'b0;
    logic               o_path_found;

    directed_graph_reachability i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_command   (i_command),
        .i_src_node  (i_src_node),
        .i_dst_node  (i_dst_node),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_path_found(o_path_found)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // requests still to be offered, and answers owed by the block
    graph_req_t   req_backlog[$];
    path_answer_t answers_due[$];

    // shadow copy of the adjacency matrix
    t_row graph_rows[NODES];

    int           err_count     = 0;
    int           accepted_reqs = 0;
    int           cycle_count   = 0;
    logic         req_taken     = 1'b0;
    graph_req_t   next_req;
    path_answer_t owed;

    wire calm = accepted_reqs >= CALM_FROM && accepted_reqs < CALM_TO;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic logic take_break();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // closure of the reached set over the shadow matrix, one or more edges
    function automatic logic path_exists(input logic [FIELD_W-1:0] from,
                                         input logic [FIELD_W-1:0] to);
        t_row seen;
        t_row prev;
        if (int'(from) >= NODES || int'(to) >= NODES)
            return 1'b0;
        seen = graph_rows[from];
        do begin
            prev = seen;
            for (int n = 0; n < NODES; n++)
                if (seen[n])
                    seen |= graph_rows[n];
        end while (seen != prev);
        return seen[to];
    endfunction

    function automatic void apply_request(input graph_req_t req);
        path_answer_t ans;
        case (req.command)
            CMD_ADD: begin
                if (int'(req.src) < NODES && int'(req.dst) < NODES)
                    graph_rows[req.src][req.dst] = 1'b1;
            end
            CMD_QUERY: begin
                ans.found = path_exists(req.src, req.dst);
                ans.src   = req.src;
                ans.dst   = req.dst;
                answers_due.push_back(ans);
            end
            CMD_CLEAR: begin
                for (int n = 0; n < NODES; n++)
                    graph_rows[n] = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic void push_req(input logic [CMD_W-1:0] command,
                                     input logic [FIELD_W-1:0] src,
                                     input logic [FIELD_W-1:0] dst);
        graph_req_t req;
        req.command = command;
        req.src     = src;
        req.dst     = dst;
        req_backlog.push_back(req);
    endfunction

    function automatic logic [FIELD_W-1:0] any_node();
        return FIELD_W'($urandom);
    endfunction

    // node at an offset inside a window of the index space, wrapping around
    function automatic logic [FIELD_W-1:0] near(input int base, input int offset);
        return FIELD_W'((base + offset) % NODES);
    endfunction

    function automatic logic [FIELD_W-1:0] pick(input int base, input int span);
        return near(base, $urandom_range(0, span - 1));
    endfunction

    function automatic void queue_directed();
        // empty graph: nothing reachable, not even across the extremes; then an edge across them holds forward only
        push_req(CMD_QUERY, 5'd0, 5'd31);
        push_req(CMD_ADD, 5'd0, 5'd31);
        push_req(CMD_QUERY, 5'd0, 5'd31);
        push_req(CMD_QUERY, 5'd31, 5'd0);
        // closing the two node cycle makes each node reach itself
        push_req(CMD_ADD, 5'd31, 5'd0);
        push_req(CMD_QUERY, 5'd0, 5'd0);
        push_req(CMD_QUERY, 5'd31, 5'd31);
        // self edge versus a lone node
        push_req(CMD_ADD, 5'd5, 5'd5);
        push_req(CMD_QUERY, 5'd5, 5'd5);
        push_req(CMD_QUERY, 5'd6, 5'd6);
        // repeated edge and the unused command leave the graph alone
        push_req(CMD_ADD, 5'd0, 5'd31);
        push_req(CMD_SPARE, 5'd31, 5'd31);
        push_req(CMD_QUERY, 5'd31, 5'd31);
        // short chain: forward only
        push_req(CMD_ADD, 5'd1, 5'd2);
        push_req(CMD_ADD, 5'd2, 5'd3);
        push_req(CMD_ADD, 5'd3, 5'd4);
        push_req(CMD_QUERY, 5'd1, 5'd4);
        push_req(CMD_QUERY, 5'd4, 5'd1);
        // clear wipes every edge, self edges included
        push_req(CMD_CLEAR, 5'd31, 5'd31);
        push_req(CMD_QUERY, 5'd0, 5'd31);
        push_req(CMD_QUERY, 5'd5, 5'd5);
        push_req(CMD_ADD, 5'd31, 5'd31);
        push_req(CMD_ADD, 5'd0, 5'd0);
        push_req(CMD_QUERY, 5'd31, 5'd31);
        push_req(CMD_QUERY, 5'd0, 5'd0);
    endfunction

    // episodes: mostly clear, build a small graph in a window, then query it
    function automatic void queue_random(input int total);
        int base;
        int span;
        int count;
        while (req_backlog.size() < total) begin
            if ($urandom_range(0, 4) != 0)
                push_req(CMD_CLEAR, any_node(), any_node());
            base = $urandom_range(0, NODES - 1);
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(9, NODES)
                                               : $urandom_range(2, 8);
            if ($urandom_range(0, 5) == 0) begin
                // chain through the window, sometimes closed into a ring
                for (int k = 0; k < span - 1; k++)
                    push_req(CMD_ADD, near(base, k), near(base, k + 1));
                if ($urandom_range(0, 1) != 0)
                    push_req(CMD_ADD, near(base, span - 1), near(base, 0));
            end else begin
                count = $urandom_range(1, 2 * span);
                for (int k = 0; k < count; k++)
                    push_req(CMD_ADD, pick(base, span), pick(base, span));
            end
            count = $urandom_range(2, 10);
            for (int k = 0; k < count; k++) begin
                case ($urandom_range(0, 19))
                    0:       push_req(CMD_SPARE, any_node(), any_node());
                    1:       push_req(CMD_QUERY, any_node(), any_node());
                    2:       push_req(CMD_ADD, pick(base, span), pick(base, span));
                    default: push_req(CMD_QUERY, pick(base, span), pick(base, span));
                endcase
            end
        end
    endfunction

    // request driver: a request stays up until taken, then the next or a gap
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_req_valid || req_taken) begin
                if (req_backlog.size() != 0 && !take_break()) begin
                    next_req = req_backlog.pop_front();
                    i_command   <= next_req.command;
                    i_src_node  <= next_req.src;
                    i_dst_node  <= next_req.dst;
                    i_req_valid <= 1'b1;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
            i_rsp_ready <= !take_break();
        end
    end

    // monitor: check responses against the oldest answer owed, then update
    // the shadow graph with any request taken at this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_req_valid && o_req_ready;
            if (o_rsp_valid && i_rsp_ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch($sformatf("response with no query waiting, path_found %b",
                                              o_path_found));
                end else begin
                    owed = answers_due.pop_front();
                    if (o_path_found !== owed.found)
                        report_mismatch($sformatf("query %0d -> %0d: path_found %b, want %b",
                                                  owed.src, owed.dst, o_path_found,
                                                  owed.found));
                end
            end
            if (i_req_valid && o_req_ready) begin
                next_req.command = i_command;
                next_req.src     = i_src_node;
                next_req.dst     = i_dst_node;
                apply_request(next_req);
                accepted_reqs++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        for (int n = 0; n < NODES; n++)
            graph_rows[n] = '0;
        queue_directed();
        queue_random(req_backlog.size() + RANDOM_REQS);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || i_req_valid)
            @(posedge i_clk);
        while (answers_due.size() != 0)
            @(posedge i_clk);
        // a late walk could still post a stray response
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
